>>> hdl/stt_pkg.sv
// stt_pkg: shared constants and display operation codes for the
// two-line text terminal; no dependencies
`default_nettype none

package stt_pkg;

   // column counter width and byte width
   localparam int COL_W  = 6;
   localparam int BYTE_W = 8;

   // display operations carried on the result channel
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_WRITE = 2'd1,
      OP_HOME  = 2'd2
   } disp_op_type;

   // character codes of interest
   localparam logic [BYTE_W-1:0] CH_NEWLINE      = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH    = 8'h5c;
   localparam logic [BYTE_W-1:0] CH_PRINT_LO     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PRINT_END    = 8'h7f;
   localparam logic [BYTE_W-1:0] GLYPH_BACKSLASH = 8'h01;
   localparam logic [BYTE_W-1:0] GLYPH_NONE      = 8'h00;

endpackage

`default_nettype wire

>>> hdl/scrolling_two_line_text_terminal.sv
// Two-line scrolling text terminal: accepts one item (byte or clear
// request) when idle and emits its display operations one per cycle
// while the result output is not stalled. No new item is taken until the
// last result of the item before is loaded; the replay reads one line
// store entry per result, and a result waiting in the output
// register never holds off item acceptance. Reset clears cursor, newline
// flag and control; the line store needs no clearing pass.
// Top level; uses stt_pkg, stt_seq and stt_line_mem
`default_nettype none

module scrolling_two_line_text_terminal #(
   parameter int LINE_WIDTH = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_command,
   input  wire logic [stt_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [1:0]                 rsp_display_op,
   output logic      [stt_pkg::BYTE_W-1:0] rsp_glyph,
   output logic                            rsp_last
);
   import stt_pkg::*;

   localparam int AW = $clog2(LINE_WIDTH);

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;

   // sequencer
   stt_seq #(
      .LINE_WIDTH (LINE_WIDTH),
      .AW         (AW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_display_op (rsp_display_op),
      .rsp_glyph      (rsp_glyph),
      .rsp_last       (rsp_last),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   // line store
   stt_line_mem #(
      .DEPTH (LINE_WIDTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

>>> hdl/stt_line_mem.sv
// stt_line_mem: line store of the bottom display line, one write port and
// one read port with registered read data; uses stt_pkg
`default_nettype none

module stt_line_mem #(
   parameter int DEPTH = 40,
   parameter int AW    = 6
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [AW-1:0]             waddr,
   input  wire logic [stt_pkg::BYTE_W-1:0] wdata,
   input  wire logic [AW-1:0]             raddr,
   output logic      [stt_pkg::BYTE_W-1:0] rdata
);
   import stt_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/stt_seq.sv
// stt_seq: item decode, scroll and replay sequencer and result register;
// drives the line store read and write ports; uses stt_pkg
`default_nettype none

module stt_seq #(
   parameter int LINE_WIDTH = 40,
   parameter int AW         = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // item input
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_command,
   input  wire logic [stt_pkg::BYTE_W-1:0] req_rx_byte,
   // result output
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [1:0]                 rsp_display_op,
   output logic      [stt_pkg::BYTE_W-1:0] rsp_glyph,
   output logic                            rsp_last,
   // line store
   output logic                            mem_we,
   output logic      [AW-1:0]              mem_waddr,
   output logic      [stt_pkg::BYTE_W-1:0] mem_wdata,
   output logic      [AW-1:0]              mem_raddr,
   input  wire logic [stt_pkg::BYTE_W-1:0] mem_rdata
);
   import stt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CLEAR  = 5'b00010,
      ST_REPLAY = 5'b00100,
      ST_HOME   = 5'b01000,
      ST_PUT    = 5'b10000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [COL_W-1:0]   cursor_ff, cursor_in;
   logic               pending_ff, pending_in;
   logic               clr_ff, clr_in;
   logic               put_ff, put_in;
   logic [BYTE_W-1:0]  glyph_ff, glyph_in;
   logic [AW-1:0]      idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   disp_op_type        rsp_op_ff, rsp_op_in;
   logic [BYTE_W-1:0]  rsp_glyph_ff, rsp_glyph_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               load;
   logic               is_nl, is_bs, is_print, put_c, full_c, scroll_c;
   logic [BYTE_W-1:0]  glyph_c;

   // byte classification of the offered item
   always_comb begin
      is_nl    = (req_rx_byte == CH_NEWLINE);
      is_bs    = (req_rx_byte == CH_BACKSLASH);
      is_print = (req_rx_byte >= CH_PRINT_LO) && (req_rx_byte < CH_PRINT_END);
      put_c    = !req_command && (is_bs || is_print);
      glyph_c  = is_bs ? GLYPH_BACKSLASH : req_rx_byte;
      full_c   = (cursor_ff >= COL_W'(LINE_WIDTH));
      scroll_c = req_command || pending_ff || (put_c && full_c);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      pending_in   = pending_ff;
      clr_in       = clr_ff;
      put_in       = put_ff;
      glyph_in     = glyph_ff;
      idx_in       = idx_ff;
      load         = 1'b0;
      rsp_op_in    = OP_CLEAR;
      rsp_glyph_in = GLYPH_NONE;
      rsp_last_in  = 1'b0;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               clr_in   = req_command;
               put_in   = put_c;
               glyph_in = glyph_c;
               idx_in   = '0;
               if (!req_command) begin
                  pending_in = is_nl;
               end
               if (scroll_c) begin
                  state_in = ST_CLEAR;
               end else if (put_c) begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               load      = 1'b1;
               rsp_op_in = OP_CLEAR;
               if (!clr_ff && (cursor_ff != '0)) begin
                  state_in = ST_REPLAY;
               end else begin
                  state_in = ST_HOME;
               end
            end
         end
         ST_REPLAY: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_op_in    = OP_WRITE;
               rsp_glyph_in = mem_rdata;
               // stored entries run up to the cursor, none of them zero
               if (COL_W'(idx_ff) + COL_W'(1) == cursor_ff) begin
                  state_in = ST_HOME;
               end else begin
                  idx_in = AW'(idx_ff + AW'(1));
               end
            end
         end
         ST_HOME: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_op_in   = OP_HOME;
               rsp_last_in = !put_ff;
               cursor_in   = '0;
               state_in    = put_ff ? ST_PUT : ST_IDLE;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_op_in    = OP_WRITE;
               rsp_glyph_in = glyph_ff;
               rsp_last_in  = 1'b1;
               mem_we       = 1'b1;
               cursor_in    = COL_W'(cursor_ff + COL_W'(1));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read address follows the next index so data lines up with idx_ff
   assign mem_raddr = idx_in;
   assign mem_waddr = cursor_ff[AW-1:0];
   assign mem_wdata = glyph_ff;

   assign rsp_valid_in = load ? 1'b1 : (rsp_stall & rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      clr_ff   <= clr_in;
      put_ff   <= put_in;
      glyph_ff <= glyph_in;
      idx_ff   <= idx_in;
      if (load) begin
         rsp_op_ff    <= rsp_op_in;
         rsp_glyph_ff <= rsp_glyph_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_display_op = rsp_op_ff;
   assign rsp_glyph      = rsp_glyph_ff;
   assign rsp_last       = rsp_last_ff;

   // cursor never passes the end of the line
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= COL_W'(LINE_WIDTH))
      else $error("cursor beyond line width");

   // replay only reads entries below the cursor
   a_replay_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLAY) |-> (COL_W'(idx_ff) < cursor_ff))
      else $error("replay index not below cursor");

   // no store write while the line is being replayed
   a_no_write_replay: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLAY) |-> !mem_we)
      else $error("store write during replay");

   // cursor home result puts the column back to zero
   a_home_cursor: assert property (@(posedge clock) disable iff (reset)
      (load && state_ff == ST_HOME) |=> (cursor_ff == '0))
      else $error("cursor not reset by home");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for the two-line scrolling text terminal;
// drives bytes and clear requests, predicts display operations and checks them
// depends on stt_pkg and scrolling_two_line_text_terminal
module testbench;
   import stt_pkg::*;

   localparam int LINE_W     = 40;
   localparam int RAND_ITEMS = 120;
   localparam int MAX_CYCLES = 600000;
   localparam int TAIL_WAIT  = 60;

   // one display operation as seen on the result channel
   typedef struct packed {
      disp_op_type        op;
      logic [BYTE_W-1:0]  glyph;
      logic               last;
   } disp_result_type;

   // one input item plus its pacing hints
   typedef struct packed {
      logic               command;
      logic [BYTE_W-1:0]  rx_byte;
      logic               drain;
      logic               brisk;
   } term_item_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic                req_command = 1'b0;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [1:0]          rsp_display_op;
   logic [BYTE_W-1:0]   rsp_glyph;
   logic                rsp_last;

   // predicted terminal state
   logic [BYTE_W-1:0]   shadow_line [LINE_W];
   logic [COL_W-1:0]    shadow_col;
   logic                shadow_nl;

   disp_result_type     step_ops[$];
   disp_result_type     due_ops[$];
   term_item_type       send_items[$];
   term_item_type       cur_item;

   int                  items_total = 0;
   int                  items_taken = 0;
   int                  fail_count  = 0;
   int                  cycle_count = 0;
   int                  gap_left    = 0;
   int                  stall_left  = 0;
   logic                brisk_phase = 1'b0;
   logic                brisk_gen   = 1'b0;
   logic                drain_next  = 1'b0;

   scrolling_two_line_text_terminal #(
      .LINE_WIDTH(LINE_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_display_op (rsp_display_op),
      .rsp_glyph      (rsp_glyph),
      .rsp_last       (rsp_last)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   task automatic emit_op(input disp_op_type op, input logic [BYTE_W-1:0] g);
      disp_result_type r;
      r.op    = op;
      r.glyph = g;
      r.last  = 1'b0;
      step_ops.push_back(r);
   endtask

   // clear, replay stored line on the top line, home the cursor
   task automatic scroll_line();
      emit_op(OP_CLEAR, GLYPH_NONE);
      for (int i = 0; i < LINE_W; i++) begin
         if (shadow_line[i] == GLYPH_NONE)
            break;
         emit_op(OP_WRITE, shadow_line[i]);
      end
      for (int i = 0; i < LINE_W; i++)
         shadow_line[i] = GLYPH_NONE;
      emit_op(OP_HOME, GLYPH_NONE);
      shadow_col = '0;
   endtask

   // write at the cursor, scrolling first on a full line
   task automatic write_glyph(input logic [BYTE_W-1:0] g);
      if (shadow_col >= LINE_W)
         scroll_line();
      emit_op(OP_WRITE, g);
      if (shadow_col < LINE_W)
         shadow_line[shadow_col] = g;
      shadow_col = shadow_col + 1'b1;
   endtask

   task automatic predict_terminal(input logic cmd, input logic [BYTE_W-1:0] ch);
      disp_result_type r;
      step_ops.delete();
      if (cmd) begin
         emit_op(OP_CLEAR, GLYPH_NONE);
         emit_op(OP_HOME, GLYPH_NONE);
         shadow_col = '0;
         for (int i = 0; i < LINE_W; i++)
            shadow_line[i] = GLYPH_NONE;
      end else begin
         if (shadow_nl)
            scroll_line();
         if (ch == CH_NEWLINE) begin
            shadow_nl = 1'b1;
         end else begin
            shadow_nl = 1'b0;
            if (ch == CH_BACKSLASH)
               write_glyph(GLYPH_BACKSLASH);
            else if (ch >= CH_PRINT_LO && ch < CH_PRINT_END)
               write_glyph(ch);
         end
      end
      // mark the end of this item's run
      if (step_ops.size() != 0) begin
         r = step_ops.pop_back();
         r.last = 1'b1;
         step_ops.push_back(r);
      end
      while (step_ops.size() != 0)
         due_ops.push_back(step_ops.pop_front());
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   task automatic queue_item(input logic cmd, input logic [BYTE_W-1:0] ch);
      term_item_type it;
      it.command = cmd;
      it.rx_byte = ch;
      it.drain   = drain_next;
      it.brisk   = brisk_gen;
      drain_next = 1'b0;
      send_items.push_back(it);
      items_total++;
   endtask

   function automatic logic [BYTE_W-1:0] line_char();
      if ($urandom_range(0, 9) == 0)
         return CH_BACKSLASH;
      return BYTE_W'($urandom_range(32'h20, 32'h7e));
   endfunction

   task automatic build_stimulus();
      int len;
      int kind;
      logic first_long;
      first_long = 1'b1;

      // directed: field extremes and special cases
      queue_item(1'b1, 8'hff);           // clear request on an empty terminal
      queue_item(1'b0, CH_PRINT_LO);     // lowest printable
      queue_item(1'b0, 8'h7e);           // highest printable
      queue_item(1'b0, 8'h41);
      queue_item(1'b0, CH_BACKSLASH);    // custom glyph
      queue_item(1'b0, CH_PRINT_END);    // dropped bytes
      queue_item(1'b0, 8'h1f);
      queue_item(1'b0, 8'h00);
      queue_item(1'b0, 8'hff);
      queue_item(1'b0, CH_NEWLINE);      // sets pending, no result
      queue_item(1'b0, CH_NEWLINE);      // pending scroll, stays pending
      queue_item(1'b0, 8'h80);           // dropped byte runs pending scroll
      queue_item(1'b0, 8'h42);
      queue_item(1'b0, CH_NEWLINE);
      queue_item(1'b1, CH_NEWLINE);      // clear keeps the pending flag
      queue_item(1'b0, 8'h43);           // scroll of an empty store then write
      queue_item(1'b0, CH_NEWLINE);
      queue_item(1'b0, CH_BACKSLASH);    // scroll then custom glyph
      queue_item(1'b1, 8'h00);

      // random: mostly text lines ended by newline, some noise
      drain_next = 1'b1;
      while (items_total < RAND_ITEMS) begin
         if ($urandom_range(0, 5) == 0)
            brisk_gen = ~brisk_gen;
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            if (first_long)
               len = $urandom_range(41, 44);
            else if ($urandom_range(0, 9) < 7)
               len = $urandom_range(0, 12);
            else
               len = $urandom_range(30, 44);
            first_long = 1'b0;
            for (int i = 0; i < len; i++)
               queue_item(1'b0, line_char());
            if ($urandom_range(0, 7) != 0)
               queue_item(1'b0, CH_NEWLINE);
         end else if (kind == 7) begin
            queue_item(1'b1, BYTE_W'($urandom_range(0, 255)));
         end else begin
            queue_item(1'b0, BYTE_W'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 24) == 0)
            drain_next = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_terminal(cur_item.command, cur_item.rx_byte);
            items_taken++;
            gap_left = brisk_phase ? 0 : $urandom_range(0, 12);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_items.size() != 0 &&
                         !(send_items[0].drain && due_ops.size() != 0)) begin
               cur_item     = send_items.pop_front();
               brisk_phase  = cur_item.brisk;
               req_valid   <= 1'b1;
               req_command <= cur_item.command;
               req_rx_byte <= cur_item.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor and checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      disp_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_ops.size() == 0) begin
               $display("%0t: unexpected result op %0d glyph %0h last %0b", $time,
                        rsp_display_op, rsp_glyph, rsp_last);
               fail_count++;
            end else begin
               want = due_ops.pop_front();
               if (rsp_display_op != want.op) begin
                  $display("%0t: display_op expected %0d, got %0d", $time,
                           want.op, rsp_display_op);
                  fail_count++;
               end
               if (rsp_glyph != want.glyph) begin
                  $display("%0t: glyph expected %0h, got %0h", $time,
                           want.glyph, rsp_glyph);
                  fail_count++;
               end
               if (rsp_last != want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time,
                           want.last, rsp_last);
                  fail_count++;
               end
            end
            stall_left = brisk_phase ? 0 : $urandom_range(0, 12);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // ---------------------------------------------------------------------
   // run control
   // ---------------------------------------------------------------------
   initial begin
      shadow_col = '0;
      shadow_nl  = 1'b0;
      for (int i = 0; i < LINE_W; i++)
         shadow_line[i] = GLYPH_NONE;
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (items_taken < items_total)
         @(posedge clock);
      while (due_ops.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0 && due_ops.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
